@@ src/four_player_link_hub_defines.svh @@
// Assertion macros shared by the four-player link hub RTL
`ifndef FOUR_PLAYER_LINK_HUB_DEFINES_SVH
`define FOUR_PLAYER_LINK_HUB_DEFINES_SVH

// Plain property, checked on every rising clock edge outside reset
`define FPLH_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication
`define FPLH_ASSERT_IMPL(label, ante, cons, msg) \
  `FPLH_ASSERT(label, (ante) |-> (cons), msg)

// Next-cycle implication
`define FPLH_ASSERT_NEXT(label, ante, cons, msg) \
  `FPLH_ASSERT(label, (ante) |=> (cons), msg)

`endif

@@ src/fplh_pkg.sv @@
// Types and constants shared by the four-player link hub modules
package fplh_pkg;

  localparam int unsigned DefMaxDataNumber = 64;

  localparam logic [7:0] ByteSync    = 8'hFE;
  localparam logic [7:0] ByteStart   = 8'hCC;
  localparam logic [7:0] ByteDnReq   = 8'h88;
  localparam logic [7:0] ByteGo      = 8'hAA;

  typedef enum logic [1:0] {
    MODE_CONN  = 2'd0,
    MODE_START = 2'd1,
    MODE_DATA  = 2'd2,
    MODE_IDLE  = 2'd3
  } hub_mode_e;

  typedef enum logic [3:0] {
    ST_WAIT   = 4'b0001,
    ST_SLOT   = 4'b0010,
    ST_FRAME  = 4'b0100,
    ST_GATHER = 4'b1000
  } ctrl_state_e;

  typedef struct packed {
    logic latch_in;
    logic slot_step;
    logic frame_eval;
  } ctrl_cmd_t;

  typedef struct packed {
    logic gather_req;
    logic gather_busy;
  } dp_status_t;

endpackage

@@ src/fplh_ctrl.sv @@
// Sequencer for the four-player link hub: request flow and result register control
`include "four_player_link_hub_defines.svh"

module fplh_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output fplh_pkg::ctrl_cmd_t    cmd_o,
  input  fplh_pkg::dp_status_t   status_i
);
  import fplh_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_busy;

  // result register still held by the receiver
  assign out_busy    = out_valid_q && out_stall_i;
  assign in_stall_o  = (state_q != ST_WAIT);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_WAIT: begin
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d        = ST_SLOT;
        end
      end
      ST_SLOT: begin
        cmd_o.slot_step = 1'b1;
        state_d         = ST_FRAME;
      end
      ST_FRAME: begin
        if (!out_busy) begin
          cmd_o.frame_eval = 1'b1;
          state_d          = status_i.gather_req ? ST_GATHER : ST_WAIT;
        end
      end
      ST_GATHER: begin
        if (!status_i.gather_busy) begin
          state_d = ST_WAIT;
        end
      end
      default: begin
        state_d = ST_WAIT;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.frame_eval) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_WAIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  `FPLH_ASSERT_IMPL(a_gather_blocks_input, status_i.gather_busy, in_stall_o, "request taken during gather")
  `FPLH_ASSERT_NEXT(a_accept_to_slot, in_valid_i && !in_stall_o, cmd_o.slot_step, "slot step missed")
  `FPLH_ASSERT_NEXT(a_eval_loads_result, cmd_o.frame_eval, out_valid_o, "result not presented")

endmodule

@@ src/fplh_dp.sv @@
// Datapath of the four-player link hub: mode state, receive/transmit stores, gather
module fplh_dp #(
  parameter int unsigned MAX_DATA_NUMBER = fplh_pkg::DefMaxDataNumber
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_wr_en_i,
  input  logic [3:0]           cfg_wr_data_i,
  input  logic                 command_i,
  input  logic [7:0]           rx_link0_i,
  input  logic [7:0]           rx_link1_i,
  input  logic [7:0]           rx_link2_i,
  input  logic [7:0]           rx_link3_i,
  input  fplh_pkg::ctrl_cmd_t  cmd_i,
  output fplh_pkg::dp_status_t status_o,
  output logic [7:0]           tx_link0_o,
  output logic [7:0]           tx_link1_o,
  output logic [7:0]           tx_link2_o,
  output logic [7:0]           tx_link3_o,
  output logic [7:0]           slot_number_o,
  output logic [1:0]           hub_mode_o,
  output logic                 frame_end_o
);
  import fplh_pkg::*;

  localparam int unsigned RxRows  = MAX_DATA_NUMBER + 1;
  localparam int unsigned RowW    = $clog2(RxRows);
  localparam int unsigned TxDepth = 4 * MAX_DATA_NUMBER;
  localparam int unsigned SlotW   = $clog2(TxDepth);
  localparam int unsigned FlenW   = $clog2(TxDepth + 1);

  // latched request
  logic             in_cmd_q;
  logic [7:0]       in_rx_q [4];

  // hub state
  logic [3:0]       mask_q, snap_q, snap_d;
  hub_mode_e        mode_q, mode_d;
  logic [SlotW-1:0] slot_q, slot_d;
  logic [FlenW-1:0] flen_q, flen_d;
  logic [7:0]       dn_q, dn_d, dn_cap;
  logic             expect_q, expect_d;
  logic             first_q, first_d;
  logic             fend_q;
  logic [FlenW-1:0] slot_next;

  // receive rows 0..3 kept in flops for the frame-end checks
  logic [7:0]       sh_q [4][4];
  logic [RxRows-1:0] valid_q;

  // receive store write side
  logic             active;
  logic             row_hit;
  logic [RowW-1:0]  wr_row;
  logic [3:0]       rx_we;
  logic [7:0]       rx_wdata [4];

  // gather
  logic             g_issue_q, g_wr_q, last_issue;
  logic [RowW-1:0]  g_row_q;
  logic [SlotW-1:0] g_pos_q, wr_pos_q;
  logic [1:0]       g_k_q, wr_k_q;
  logic [7:0]       rd_data_q [4];
  logic             rd_valid_q;

  // transmit store
  logic [7:0]       tx_mem [TxDepth];
  logic [7:0]       tx_rd_q;

  // result
  logic [7:0]       res_tx [4];
  logic [7:0]       res_slot;
  logic             res_fend;
  logic             start_hit;
  logic [7:0]       out_tx_q [4];
  logic [7:0]       out_slot_q;
  logic [1:0]       out_mode_q;
  logic             out_fend_q;

  assign status_o.gather_req  = in_cmd_q && (mode_q == MODE_DATA) && fend_q;
  assign status_o.gather_busy = g_issue_q || g_wr_q;

  assign slot_next = FlenW'(slot_q) + FlenW'(1);

  // ---- receive store writes ----
  assign active  = cmd_i.slot_step && in_cmd_q && (mode_q != MODE_IDLE);
  assign row_hit = (slot_q <= SlotW'(MAX_DATA_NUMBER));
  assign wr_row  = RowW'(slot_q);

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      // first write to a row fills absent links with zero so one valid bit covers it
      rx_we[k]    = active && row_hit && (mask_q[k] || !valid_q[wr_row]);
      rx_wdata[k] = mask_q[k] ? in_rx_q[k] : 8'h00;
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_lane
    logic [7:0] mem [RxRows];
    always_ff @(posedge clk_i) begin
      if (rx_we[k]) begin
        mem[wr_row] <= rx_wdata[k];
      end
      if (g_issue_q) begin
        rd_data_q[k] <= mem[g_row_q];
      end
    end
  end

  // ---- frame-end decisions ----
  always_comb begin
    start_hit = 1'b0;
    for (int k = 0; k < 4; k++) begin
      if (sh_q[k][1] == ByteGo && sh_q[k][2] == ByteGo && sh_q[k][3] == ByteGo) begin
        start_hit = 1'b1;
      end
    end
  end

  always_comb begin
    if (sh_q[0][0] == 8'd0) begin
      dn_cap = 8'd1;
    end else if (sh_q[0][0] > 8'(MAX_DATA_NUMBER)) begin
      dn_cap = 8'(MAX_DATA_NUMBER);
    end else begin
      dn_cap = sh_q[0][0];
    end
  end

  always_comb begin
    mode_d   = mode_q;
    slot_d   = slot_q;
    flen_d   = flen_q;
    dn_d     = dn_q;
    expect_d = expect_q;
    first_d  = first_q;
    snap_d   = snap_q;
    res_slot = 8'd0;
    res_fend = 1'b0;
    for (int k = 0; k < 4; k++) begin
      res_tx[k] = 8'h00;
    end
    if (!in_cmd_q) begin
      mode_d = MODE_CONN;
      slot_d = '0;
      flen_d = FlenW'(4);
      snap_d = mask_q;
    end else if (mode_q != MODE_IDLE) begin
      for (int k = 0; k < 4; k++) begin
        case (mode_q)
          MODE_CONN:  res_tx[k] = (slot_q == '0) ? ByteSync : {snap_q, 4'(k + 1)};
          MODE_START: res_tx[k] = ByteStart;
          MODE_DATA:  res_tx[k] = first_q ? 8'h00 : tx_rd_q;
          default:    res_tx[k] = 8'h00;
        endcase
      end
      res_slot = 8'(slot_q);
      res_fend = fend_q;
      if (fend_q) begin
        slot_d   = '0;
        if (expect_q) begin
          dn_d = dn_cap;
        end
        expect_d = (mode_q == MODE_CONN) && (sh_q[0][1] == ByteDnReq) &&
                   (sh_q[0][2] == ByteDnReq);
        case (mode_q)
          MODE_CONN: begin
            if (start_hit) begin
              mode_d = MODE_START;
              flen_d = FlenW'(4);
            end
          end
          MODE_START: begin
            mode_d  = MODE_DATA;
            flen_d  = FlenW'({dn_d, 2'b00});
            first_d = 1'b1;
          end
          MODE_DATA: begin
            first_d = 1'b0;
          end
          default: begin
            mode_d = mode_q;
          end
        endcase
      end else begin
        slot_d = SlotW'(slot_next);
      end
    end
  end

  // ---- control state ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q   <= '0;
      snap_q   <= '0;
      mode_q   <= MODE_IDLE;
      slot_q   <= '0;
      flen_q   <= FlenW'(4);
      dn_q     <= 8'd1;
      expect_q <= 1'b0;
      first_q  <= 1'b0;
      valid_q  <= '0;
      for (int k = 0; k < 4; k++) begin
        for (int r = 0; r < 4; r++) begin
          sh_q[k][r] <= 8'h00;
        end
      end
    end else begin
      if (cfg_wr_en_i) begin
        mask_q <= cfg_wr_data_i;
      end
      if (cmd_i.frame_eval) begin
        snap_q   <= snap_d;
        mode_q   <= mode_d;
        slot_q   <= slot_d;
        flen_q   <= flen_d;
        dn_q     <= dn_d;
        expect_q <= expect_d;
        first_q  <= first_d;
      end
      if (active && row_hit) begin
        valid_q[wr_row] <= 1'b1;
      end
      if (active && (FlenW'(slot_q) < FlenW'(4))) begin
        for (int k = 0; k < 4; k++) begin
          if (mask_q[k]) begin
            sh_q[k][slot_q[1:0]] <= in_rx_q[k];
          end
        end
      end
    end
  end

  // ---- gather sequencing: row b+1 of link k lands at k*N+b ----
  assign last_issue = (g_k_q == 2'd3) && (g_row_q == RowW'(dn_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_issue_q <= 1'b0;
      g_wr_q    <= 1'b0;
    end else begin
      g_wr_q <= g_issue_q;
      if (cmd_i.frame_eval && status_o.gather_req) begin
        g_issue_q <= 1'b1;
      end else if (g_issue_q && last_issue) begin
        g_issue_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.frame_eval && status_o.gather_req) begin
      g_row_q <= RowW'(1);
      g_pos_q <= '0;
      g_k_q   <= 2'd0;
    end else if (g_issue_q) begin
      g_pos_q <= g_pos_q + SlotW'(1);
      if (g_row_q == RowW'(dn_q)) begin
        g_row_q <= RowW'(1);
        g_k_q   <= g_k_q + 2'd1;
      end else begin
        g_row_q <= g_row_q + RowW'(1);
      end
    end
    wr_pos_q   <= g_pos_q;
    wr_k_q     <= g_k_q;
    rd_valid_q <= valid_q[g_row_q];
  end

  always_ff @(posedge clk_i) begin
    if (g_wr_q) begin
      tx_mem[wr_pos_q] <= rd_valid_q ? rd_data_q[wr_k_q] : 8'h00;
    end
    if (cmd_i.slot_step) begin
      tx_rd_q <= tx_mem[slot_q];
    end
  end

  // ---- request latch and result register ----
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      in_cmd_q   <= command_i;
      in_rx_q[0] <= rx_link0_i;
      in_rx_q[1] <= rx_link1_i;
      in_rx_q[2] <= rx_link2_i;
      in_rx_q[3] <= rx_link3_i;
    end
    if (cmd_i.slot_step) begin
      fend_q <= (slot_next == flen_q);
    end
    if (cmd_i.frame_eval) begin
      for (int k = 0; k < 4; k++) begin
        out_tx_q[k] <= res_tx[k];
      end
      out_slot_q <= res_slot;
      out_mode_q <= mode_d;
      out_fend_q <= res_fend;
    end
  end

  assign tx_link0_o    = out_tx_q[0];
  assign tx_link1_o    = out_tx_q[1];
  assign tx_link2_o    = out_tx_q[2];
  assign tx_link3_o    = out_tx_q[3];
  assign slot_number_o = out_slot_q;
  assign hub_mode_o    = out_mode_q;
  assign frame_end_o   = out_fend_q;

endmodule

@@ src/four_player_link_hub.sv @@
// Top level of the four-player link hub
//
// One request is one byte slot on four serial links: command_i = 0 starts the
// connection handshake, command_i = 1 swaps one byte with each link. Every
// request gives exactly one result (the four transmit bytes, slot number, the
// mode after the slot and a frame-end flag). Both channels use valid/stall.
// The connected_mask register (cfg_wr_en_i / cfg_wr_data_i) is to be written
// while no request is in flight; the block itself does not enforce this.
// A start request samples it into the status bytes. A request is taken only
// in the wait state and then passes the slot step and the frame evaluation,
// which loads the result register, before the next one is taken. A frame end
// in data mode adds the broadcast gather, one transmit-store write per cycle.
// The result sits in an output register; while the receiver stalls, the next
// request is still taken and held until that register frees up.
// Reset puts the hub in idle mode (slots are answered with zeros and mode 3),
// clears the receive store's contents by valid bits on its rows, and sets the
// data number to one. No clearing pass is needed.
module four_player_link_hub #(
  parameter int unsigned MAX_DATA_NUMBER = fplh_pkg::DefMaxDataNumber
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_wr_en_i,
  input  logic [3:0] cfg_wr_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       command_i,
  input  logic [7:0] rx_link0_i,
  input  logic [7:0] rx_link1_i,
  input  logic [7:0] rx_link2_i,
  input  logic [7:0] rx_link3_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] tx_link0_o,
  output logic [7:0] tx_link1_o,
  output logic [7:0] tx_link2_o,
  output logic [7:0] tx_link3_o,
  output logic [7:0] slot_number_o,
  output logic [1:0] hub_mode_o,
  output logic       frame_end_o
);
  import fplh_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // sequencer: request handshake, slot step, frame evaluation, gather wait
  fplh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  // mode state, receive and transmit stores, result register
  fplh_dp #(
    .MAX_DATA_NUMBER (MAX_DATA_NUMBER)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .command_i     (command_i),
    .rx_link0_i    (rx_link0_i),
    .rx_link1_i    (rx_link1_i),
    .rx_link2_i    (rx_link2_i),
    .rx_link3_i    (rx_link3_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .tx_link0_o    (tx_link0_o),
    .tx_link1_o    (tx_link1_o),
    .tx_link2_o    (tx_link2_o),
    .tx_link3_o    (tx_link3_o),
    .slot_number_o (slot_number_o),
    .hub_mode_o    (hub_mode_o),
    .frame_end_o   (frame_end_o)
  );

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for the four-player link hub: directed and random slot traffic
`timescale 1ns / 100ps

module testbench;
  import fplh_pkg::*;

  // Hub geometry, as the default build of the block sees it
  localparam int unsigned MaxDn      = DefMaxDataNumber;
  localparam int unsigned StoreDepth = 4 * MaxDn;
  // Wait long enough for the worst data-mode gather of the largest data number
  localparam int unsigned GatherWait = 4 * MaxDn + 16;
  localparam int unsigned CycleLimit = 1_000_000;
  // Random requests per phase; sessions are whole, so a phase may run over
  localparam int unsigned PhaseReqs  = 20;

  // command_i codes
  localparam logic CmdStart = 1'b0;
  localparam logic CmdSlot  = 1'b1;

  // One request: the command and the byte shifted in from each link
  typedef struct packed {
    logic            cmd;
    logic [3:0][7:0] rx;
  } slot_req_t;

  // One result: what goes out on each link plus slot bookkeeping
  typedef struct packed {
    logic [3:0][7:0] tx;
    logic [7:0]      slot;
    hub_mode_e       mode;
    logic            fend;
  } slot_res_t;

  logic       clk_i;
  logic       rst_ni        = 1'b0;
  logic       cfg_wr_en_i   = 1'b0;
  logic [3:0] cfg_wr_data_i = '0;
  logic       in_valid_i    = 1'b0;
  logic       in_stall_o;
  logic       command_i     = CmdSlot;
  logic [7:0] rx_link0_i    = '0;
  logic [7:0] rx_link1_i    = '0;
  logic [7:0] rx_link2_i    = '0;
  logic [7:0] rx_link3_i    = '0;
  logic       out_valid_o;
  logic       out_stall_i   = 1'b0;
  logic [7:0] tx_link0_o;
  logic [7:0] tx_link1_o;
  logic [7:0] tx_link2_o;
  logic [7:0] tx_link3_o;
  logic [7:0] slot_number_o;
  logic [1:0] hub_mode_o;
  logic       frame_end_o;

  four_player_link_hub dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .command_i     (command_i),
    .rx_link0_i    (rx_link0_i),
    .rx_link1_i    (rx_link1_i),
    .rx_link2_i    (rx_link2_i),
    .rx_link3_i    (rx_link3_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .tx_link0_o    (tx_link0_o),
    .tx_link1_o    (tx_link1_o),
    .tx_link2_o    (tx_link2_o),
    .tx_link3_o    (tx_link3_o),
    .slot_number_o (slot_number_o),
    .hub_mode_o    (hub_mode_o),
    .frame_end_o   (frame_end_o)
  );

  // 4 ns clock
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // ---------------------------------------------------------------------------
  // Behavioral hub: our own copy of the stores, slot counter and mode
  // ---------------------------------------------------------------------------
  logic [7:0]  hub_tx [4][StoreDepth];
  logic [7:0]  hub_rx [4][StoreDepth];
  int unsigned slot_idx;
  int unsigned frame_len;
  int unsigned data_num;
  hub_mode_e   hub_mode;
  logic        dn_armed;   // link 0 asked for a data number last frame
  logic [3:0]  link_mask;  // mirror of connected_mask

  function automatic void hub_reset();
    for (int k = 0; k < 4; k++) begin
      for (int i = 0; i < StoreDepth; i++) begin
        hub_tx[k][i] = '0;
        hub_rx[k][i] = '0;
      end
    end
    link_mask = '0;
    slot_idx  = 0;
    frame_len = 4;
    hub_mode  = MODE_IDLE;
    data_num  = 1;
    dn_armed  = 1'b0;
  endfunction

  // Sync byte, then three status bytes: mask in the high nibble, unit number low
  function automatic void enter_conn();
    frame_len = 4;
    for (int k = 0; k < 4; k++) begin
      hub_tx[k][0] = ByteSync;
      for (int i = 1; i < 4; i++) hub_tx[k][i] = {link_mask, 4'(k + 1)};
    end
    slot_idx = 0;
    hub_mode = MODE_CONN;
  endfunction

  function automatic void enter_start();
    frame_len = 4;
    for (int k = 0; k < 4; k++) begin
      for (int i = 0; i < 4; i++) hub_tx[k][i] = ByteStart;
    end
    slot_idx = 0;
    hub_mode = MODE_START;
  endfunction

  function automatic void enter_data();
    frame_len = 4 * data_num;
    for (int k = 0; k < 4; k++) begin
      for (int i = 0; i < frame_len; i++) hub_tx[k][i] = '0;
    end
    slot_idx = 0;
    hub_mode = MODE_DATA;
  endfunction

  function automatic void close_frame();
    int unsigned pos;
    // data number capture, clamped to 1..MaxDn; the flag only lives one frame
    if (dn_armed) begin
      if (hub_rx[0][0] == 8'd0) data_num = 1;
      else if (hub_rx[0][0] > MaxDn) data_num = MaxDn;
      else data_num = hub_rx[0][0];
    end
    dn_armed = 1'b0;
    case (hub_mode)
      MODE_CONN: begin
        if (hub_rx[0][1] == ByteDnReq && hub_rx[0][2] == ByteDnReq) dn_armed = 1'b1;
        // a link answering 88,88 is skipped even if slot 3 holds AA
        for (int k = 0; k < 4; k++) begin
          if (!(hub_rx[k][1] == ByteDnReq && hub_rx[k][2] == ByteDnReq) &&
              hub_rx[k][1] == ByteGo && hub_rx[k][2] == ByteGo &&
              hub_rx[k][3] == ByteGo) enter_start();
        end
      end
      MODE_START: enter_data();
      MODE_DATA: begin
        // gather bytes 1..N of each link in link order, then broadcast
        for (int k = 0; k < 4; k++) begin
          for (int b = 0; b < data_num; b++) begin
            pos = k * data_num + b;
            if (pos < frame_len && pos < StoreDepth) hub_tx[0][pos] = hub_rx[k][b + 1];
          end
        end
        for (int k = 1; k < 4; k++) begin
          for (int i = 0; i < frame_len; i++) hub_tx[k][i] = hub_tx[0][i];
        end
      end
      default: ;
    endcase
  endfunction

  function automatic slot_res_t hub_slot(slot_req_t r);
    slot_res_t   res;
    int unsigned s;
    res = '0;
    if (r.cmd == CmdStart) begin
      enter_conn();
      res.mode = MODE_CONN;
      return res;
    end
    if (hub_mode == MODE_IDLE) begin
      res.mode = MODE_IDLE;
      return res;
    end
    s = (slot_idx >= StoreDepth) ? 0 : slot_idx;
    for (int k = 0; k < 4; k++) begin
      res.tx[k] = hub_tx[k][s];
      // disconnected links keep whatever they held before
      if (link_mask[k]) hub_rx[k][s] = r.rx[k];
    end
    res.slot = s[7:0];
    slot_idx = s + 1;
    if (slot_idx >= frame_len) begin
      close_frame();
      slot_idx = 0;
      res.fend = 1'b1;
    end
    res.mode = hub_mode;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Request source: queue filled by the sequence below, drained by the driver
  // ---------------------------------------------------------------------------
  slot_req_t   slot_reqs[$];
  slot_res_t   due_slots[$];
  int unsigned reqs_driven = 0;
  int unsigned reqs_taken  = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;

  function automatic slot_req_t noise_req(logic cmd);
    slot_req_t r;
    r.cmd = cmd;
    r.rx  = $urandom();
    return r;
  endfunction

  function automatic void push_req(logic cmd, logic [7:0] b0, logic [7:0] b1,
                                   logic [7:0] b2, logic [7:0] b3);
    slot_req_t r;
    r.cmd = cmd;
    r.rx  = {b3, b2, b1, b0};
    slot_reqs.push_back(r);
  endfunction

  // One well-formed handshake with random content: start, data number request,
  // data number plus go, start frame, a few data frames. Some get broken.
  function automatic void queue_session(logic [3:0] mask, logic force_big);
    slot_req_t   r;
    logic [7:0]  dn_byte;
    logic        ask_dn;
    logic        half_ask;
    logic        good_go;
    int unsigned go_link;
    int unsigned dn;
    int unsigned frames;
    int unsigned cut;
    int unsigned n;
    // stray requests ahead of the start command
    if ($urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++)
        slot_reqs.push_back(noise_req(($urandom_range(0, 3) != 0) ? CmdSlot : CmdStart));
    end
    slot_reqs.push_back(noise_req(CmdStart));

    // first connection frame: link 0 asks for a data number (88,88)
    ask_dn   = ($urandom_range(0, 3) != 0);
    half_ask = ($urandom_range(0, 7) == 0);
    for (int s = 0; s < 4; s++) begin
      r = noise_req(CmdSlot);
      if (ask_dn && (s == 1 || (s == 2 && !half_ask))) r.rx[0] = ByteDnReq;
      slot_reqs.push_back(r);
    end

    // second frame: the data number from link 0, AA,AA,AA from a connected link
    if (force_big) dn_byte = 8'hFF;
    else begin
      case ($urandom_range(0, 9))
        0:       dn_byte = 8'h00;
        9:       dn_byte = 8'($urandom_range(5, 8));
        default: dn_byte = 8'($urandom_range(1, 4));
      endcase
    end
    go_link = $urandom_range(0, 3);
    if (mask != 4'h0) begin
      while (!mask[go_link]) go_link = $urandom_range(0, 3);
    end
    good_go = ($urandom_range(0, 7) != 0);
    for (int s = 0; s < 4; s++) begin
      r = noise_req(CmdSlot);
      if (s == 0) r.rx[0] = dn_byte;
      else if (s < 3 || good_go) r.rx[go_link] = ByteGo;
      slot_reqs.push_back(r);
    end

    // start frame, then data frames sized for the requested data number
    for (int s = 0; s < 4; s++) slot_reqs.push_back(noise_req(CmdSlot));
    dn     = (dn_byte == 8'h00) ? 1 : ((dn_byte > MaxDn) ? MaxDn : dn_byte);
    frames = force_big ? 1 : $urandom_range(1, 3);
    n      = frames * 4 * dn;
    cut    = ($urandom_range(0, 9) == 0) ? $urandom_range(1, n - 1 + 1) : 0;
    for (int i = 0; i < n; i++) begin
      if (cut != 0 && i == cut) begin
        // restart in the middle of data mode
        slot_reqs.push_back(noise_req(CmdStart));
        break;
      end
      slot_reqs.push_back(noise_req(CmdSlot));
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: bursts of requests with random gaps; a request holds until taken
  // ---------------------------------------------------------------------------
  int unsigned burst_left = 8;
  int unsigned gap_left   = 0;

  always @(negedge clk_i) begin
    slot_req_t nxt;
    if (rst_ni && !(in_valid_i && reqs_taken != reqs_driven)) begin
      if (gap_left != 0) begin
        in_valid_i <= 1'b0;
        gap_left--;
      end else if (slot_reqs.size() != 0) begin
        nxt = slot_reqs.pop_front();
        command_i  <= nxt.cmd;
        rx_link0_i <= nxt.rx[0];
        rx_link1_i <= nxt.rx[1];
        rx_link2_i <= nxt.rx[2];
        rx_link3_i <= nxt.rx[3];
        in_valid_i <= 1'b1;
        reqs_driven++;
        if (burst_left > 1) burst_left--;
        else begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver back-pressure: switches at random between free-running, random,
  // heavy and periodic stalling
  int unsigned stall_style = 0;
  int unsigned stall_run   = 32;
  logic [3:0]  stall_tick  = '0;

  always @(negedge clk_i) begin
    stall_tick++;
    if (stall_run == 0) begin
      stall_style = $urandom_range(0, 3);
      stall_run   = $urandom_range(16, 128);
    end else begin
      stall_run--;
    end
    case (stall_style)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= ($urandom_range(0, 1) == 0);
      2:       out_stall_i <= ($urandom_range(0, 3) != 0);
      default: out_stall_i <= stall_tick[1];
    endcase
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each result against the oldest prediction, then predict
  // for any request taken on this edge
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    slot_req_t cur;
    slot_res_t got;
    slot_res_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got.tx[0] = tx_link0_o;
        got.tx[1] = tx_link1_o;
        got.tx[2] = tx_link2_o;
        got.tx[3] = tx_link3_o;
        got.slot  = slot_number_o;
        got.mode  = hub_mode_e'(hub_mode_o);
        got.fend  = frame_end_o;
        if (due_slots.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("unexpected result: tx=%h slot=%0d mode=%0d end=%b",
                     got.tx, got.slot, got.mode, got.fend);
        end else begin
          want = due_slots.pop_front();
          if (got.tx !== want.tx || got.slot !== want.slot ||
              got.mode !== want.mode || got.fend !== want.fend) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("mismatch: expected tx=%h slot=%0d mode=%0d end=%b, got tx=%h slot=%0d mode=%0d end=%b",
                       want.tx, want.slot, want.mode, want.fend,
                       got.tx, got.slot, got.mode, got.fend);
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        cur.cmd   = command_i;
        cur.rx[0] = rx_link0_i;
        cur.rx[1] = rx_link1_i;
        cur.rx[2] = rx_link2_i;
        cur.rx[3] = rx_link3_i;
        due_slots.push_back(hub_slot(cur));
        reqs_taken++;
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  // Mask writes only happen with nothing in flight
  task automatic write_mask(input logic [3:0] m);
    @(negedge clk_i);
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= m;
    link_mask      = m;
    @(negedge clk_i);
    cfg_wr_en_i   <= 1'b0;
  endtask

  // Wait for every request to be taken and answered, then let a gather finish
  task automatic drain();
    while (slot_reqs.size() != 0 || reqs_taken != reqs_driven || due_slots.size() != 0)
      @(posedge clk_i);
    repeat (GatherWait) @(posedge clk_i);
  endtask

  task automatic random_phase(input logic [3:0] m, input logic with_big);
    int unsigned base;
    write_mask(m);
    base = slot_reqs.size();
    queue_session(m, with_big);
    while (slot_reqs.size() - base < PhaseReqs) queue_session(m, 1'b0);
    drain();
  endtask

  initial begin
    hub_reset();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed walk through every mode, all links connected
    write_mask(4'hF);
    // idle after reset: slots are ignored
    push_req(CmdSlot, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    push_req(CmdSlot, 8'h00, 8'h00, 8'h00, 8'h00);
    push_req(CmdStart, 8'h5A, 8'hA5, 8'h0F, 8'hF0);
    // link 0 asks for a data number
    push_req(CmdSlot, 8'h00, 8'h11, 8'h22, 8'h33);
    push_req(CmdSlot, ByteDnReq, 8'h44, 8'h55, 8'h66);
    push_req(CmdSlot, ByteDnReq, 8'h77, 8'h99, 8'hAB);
    push_req(CmdSlot, 8'h55, 8'hCD, 8'hEF, 8'h01);
    // data number 0 clamps to 1; link 1 says go, link 2 answers 88,88 then AA
    push_req(CmdSlot, 8'h00, 8'hFE, 8'hCC, 8'h01);
    push_req(CmdSlot, 8'h12, ByteGo, ByteDnReq, 8'h02);
    push_req(CmdSlot, 8'h34, ByteGo, ByteDnReq, 8'h03);
    push_req(CmdSlot, 8'h56, ByteGo, ByteGo, 8'h04);
    // start frame sends CC
    for (int i = 0; i < 4; i++) push_req(CmdSlot, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    // two data frames with N = 1: byte 1 of each link comes back broadcast
    push_req(CmdSlot, 8'h80, 8'h81, 8'h82, 8'h83);
    push_req(CmdSlot, 8'h01, 8'h02, 8'h04, 8'h08);
    push_req(CmdSlot, 8'h10, 8'h20, 8'h40, 8'h80);
    push_req(CmdSlot, 8'h7F, 8'hBF, 8'hDF, 8'hEF);
    push_req(CmdSlot, 8'hFF, 8'h00, 8'hFF, 8'h00);
    push_req(CmdSlot, 8'hFE, 8'hFD, 8'hFB, 8'hF7);
    push_req(CmdSlot, 8'h00, 8'hFF, 8'h00, 8'hFF);
    push_req(CmdSlot, 8'hC3, 8'h3C, 8'h96, 8'h69);
    push_req(CmdStart, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    drain();

    // Random sessions under several masks; the all-connected phase also runs
    // one session whose data number saturates at the top
    random_phase(4'h0, 1'b0);
    random_phase(4'hF, 1'b1);
    random_phase(4'h5, 1'b0);
    random_phase(4'hA, 1'b0);
    random_phase(4'($urandom_range(1, 14)), 1'b0);

    if (mismatch_cnt == 0 && due_slots.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
